/* hw/rtl/tkps_pkg.sv */
// ----------------------------------------------------------------------------
// tkps_pkg
// Shared types and constants for the top-k priority select block: field
// layouts of the stream words, controller command and status groups.
// ----------------------------------------------------------------------------
package tkps_pkg;

    // Default sizing
    localparam int MAX_ENTRIES_DEF = 64;
    localparam int TOP_K_DEF       = 8;

    // Places in the ranked list that the output fields can carry
    localparam int OUT_PLACES = 8;

    // Field widths
    localparam int ID_W    = 64;
    localparam int TIME_W  = 32;
    localparam int PRIO_W  = 16;
    localparam int INDEX_W = 6;
    localparam int RANK_W  = 3;
    localparam int COUNT_W = 4;
    localparam int SHOWN_W = 4;

    // Reset value of max_shown
    localparam logic [SHOWN_W-1:0] MAX_SHOWN_RST = 4'd8;

    // Input tdata, last field in the lowest bits
    typedef struct packed {
        logic [TIME_W-1:0]        current_time;
        logic signed [PRIO_W-1:0] priority_req;
        logic [TIME_W-1:0]        expiry_time;
        logic [ID_W-1:0]          entry_id;
    } tkps_in_t;

    localparam int IN_TDATA_W = $bits(tkps_in_t);

    // Output tdata, last field in the lowest bits, padded to whole bytes
    typedef struct packed {
        logic [2:0]         pad;
        logic [COUNT_W-1:0] selected_count;
        logic [RANK_W-1:0]  rank;
        logic [ID_W-1:0]    selected_id;
        logic [INDEX_W-1:0] entry_index;
    } tkps_out_t;

    localparam int OUT_TDATA_W = $bits(tkps_out_t);

    // Output tuser: none_selected in bit 0, list_overflow in bit 1
    typedef struct packed {
        logic list_overflow;
        logic none_selected;
    } tkps_user_t;

    localparam int OUT_TUSER_W = $bits(tkps_user_t);

    // One stored entry
    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic [TIME_W-1:0]        expiry;
        logic [ID_W-1:0]          id;
    } tkps_entry_t;

    localparam int ENTRY_W = $bits(tkps_entry_t);

    // Controller to datapath
    typedef struct packed {
        logic load_en;    // take input items into the store
        logic sel_start;  // clear the ranked list, point at entry 0
        logic cap;        // capture the entry under test
        logic rd_j;       // read a later entry for the duplicate scan
        logic j_inc;      // advance the duplicate scan
        logic i_inc;      // advance to the next entry under test
        logic insert;     // insert the entry under test into the ranked list
        logic emit;       // load the output register with one result
    } tkps_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic load_last;  // item marked last accepted
        logic empty;      // nothing loaded
        logic skip;       // entry just read has id zero or is expired
        logic dup;        // later entry just read carries the same id
        logic last_i;     // entry under test is the final loaded entry
        logic last_j;     // scan pointer is at the final loaded entry
        logic out_free;   // output register can take a result
        logic emit_last;  // next result is the final one of the run
    } tkps_status_t;

endpackage

/* hw/rtl/tkps_ram.sv */
// ----------------------------------------------------------------------------
// tkps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tkps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

/* hw/rtl/tkps_ctrl.sv */
// ----------------------------------------------------------------------------
// tkps_ctrl
// Sequencer for load, filter, duplicate scan, ranked insertion and emit.
// ----------------------------------------------------------------------------
module tkps_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  tkps_pkg::tkps_status_t st,
    output tkps_pkg::tkps_cmd_t    cmd
);
    import tkps_pkg::*;

    typedef enum logic [7:0] {
        ST_LOAD  = 8'b0000_0001,
        ST_START = 8'b0000_0010,
        ST_RD_I  = 8'b0000_0100,
        ST_CAP   = 8'b0000_1000,
        ST_RD_J  = 8'b0001_0000,
        ST_CMP_J = 8'b0010_0000,
        ST_INS   = 8'b0100_0000,
        ST_EMIT  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_LOAD: begin
                cmd.load_en = 1'b1;
                if (st.load_last) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                cmd.sel_start = 1'b1;
                state_next    = st.empty ? ST_EMIT : ST_RD_I;
            end
            ST_RD_I: begin
                // store read of the entry under test is in flight
                state_next = ST_CAP;
            end
            ST_CAP: begin
                cmd.cap = 1'b1;
                if (st.skip) begin
                    cmd.i_inc  = 1'b1;
                    state_next = st.last_i ? ST_EMIT : ST_RD_I;
                end else if (st.last_i) begin
                    state_next = ST_INS;
                end else begin
                    state_next = ST_RD_J;
                end
            end
            ST_RD_J: begin
                cmd.rd_j   = 1'b1;
                state_next = ST_CMP_J;
            end
            ST_CMP_J: begin
                if (st.dup) begin
                    // a later entry replaces this one
                    cmd.i_inc  = 1'b1;
                    state_next = st.last_i ? ST_EMIT : ST_RD_I;
                end else if (st.last_j) begin
                    state_next = ST_INS;
                end else begin
                    cmd.j_inc  = 1'b1;
                    state_next = ST_RD_J;
                end
            end
            ST_INS: begin
                cmd.insert = 1'b1;
                cmd.i_inc  = 1'b1;
                state_next = st.last_i ? ST_EMIT : ST_RD_I;
            end
            ST_EMIT: begin
                if (st.out_free) begin
                    cmd.emit = 1'b1;
                    if (st.emit_last) begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

/* hw/rtl/tkps_dpath.sv */
// ----------------------------------------------------------------------------
// tkps_dpath
// Entry store, filter and duplicate compare, ranked list with insertion,
// output register and the max_shown register.
// ----------------------------------------------------------------------------
module tkps_dpath #(
    parameter int MAX_ENTRIES = tkps_pkg::MAX_ENTRIES_DEF,
    parameter int TOP_K       = tkps_pkg::TOP_K_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  tkps_pkg::tkps_cmd_t                  cmd,
    output tkps_pkg::tkps_status_t               st,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [tkps_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [tkps_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic [tkps_pkg::OUT_TUSER_W-1:0]     m_tuser,
    output logic                                 m_tlast,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tkps_pkg::SHOWN_W-1:0]         cfg_data
);
    import tkps_pkg::*;

    localparam int IDXW   = $clog2(MAX_ENTRIES);
    localparam int CW     = $clog2(MAX_ENTRIES + 1);
    localparam int PLACES = (TOP_K < OUT_PLACES) ? TOP_K : OUT_PLACES;
    localparam int KW     = $clog2(OUT_PLACES);

    tkps_in_t    in_word;
    tkps_entry_t wr_entry;
    tkps_entry_t rd_entry;
    logic [ENTRY_W-1:0] rd_data;
    logic [IDXW-1:0]    rd_addr;
    logic               s_fire;
    logic               store_ok;

    logic [CW-1:0]      loaded_reg;
    logic               ovf_reg;
    logic [TIME_W-1:0]  time_reg;
    logic [SHOWN_W-1:0] max_shown_reg;
    logic [IDXW-1:0]    i_reg;
    logic [CW-1:0]      j_reg;
    logic [ID_W-1:0]    cur_id_reg;
    logic signed [PRIO_W-1:0] cur_prio_reg;

    // Ranked list, highest priority first
    logic [IDXW-1:0]          rk_idx_reg  [OUT_PLACES];
    logic [ID_W-1:0]          rk_id_reg   [OUT_PLACES];
    logic signed [PRIO_W-1:0] rk_prio_reg [OUT_PLACES];
    logic [COUNT_W-1:0]       rk_cnt_reg;
    logic [KW-1:0]            k_reg;

    logic [IDXW-1:0]          ins_idx  [OUT_PLACES];
    logic [ID_W-1:0]          ins_id   [OUT_PLACES];
    logic signed [PRIO_W-1:0] ins_prio [OUT_PLACES];
    logic [OUT_PLACES-1:0]    ge;
    logic [OUT_PLACES-1:0]    ge_prev;
    logic [COUNT_W-1:0]       ins_at;
    logic [COUNT_W-1:0]       limit;
    logic                     drop;

    logic             out_valid_reg;
    tkps_out_t        out_data_reg;
    tkps_user_t       out_user_reg;
    logic             out_last_reg;
    tkps_out_t        emit_data;
    tkps_user_t       emit_user;
    logic             emit_last;

    assign in_word  = s_tdata;
    assign s_tready = cmd.load_en;
    assign s_fire   = s_tvalid & cmd.load_en;
    assign store_ok = loaded_reg < CW'(MAX_ENTRIES);

    assign cfg_ready = 1'b1;

    // Entry store
    assign wr_entry.id     = in_word.entry_id;
    assign wr_entry.expiry = in_word.expiry_time;
    assign wr_entry.prio   = in_word.priority_req;
    assign rd_addr         = cmd.rd_j ? j_reg[IDXW-1:0] : i_reg;
    assign rd_entry        = rd_data;

    tkps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .clk     (aclk),
        .wr_en   (s_fire & store_ok),
        .wr_addr (loaded_reg[IDXW-1:0]),
        .wr_data (wr_entry),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Effective number of places
    assign limit = (max_shown_reg > COUNT_W'(PLACES)) ? COUNT_W'(PLACES) : max_shown_reg;

    // Insertion point: slots holding a priority at or above the new one
    always_comb begin
        ins_at = '0;
        for (int k = 0; k < OUT_PLACES; k++) begin
            ge[k]  = (COUNT_W'(k) < rk_cnt_reg) && (rk_prio_reg[k] >= cur_prio_reg);
            ins_at = ins_at + COUNT_W'(ge[k]);
        end
        ge_prev = {ge[OUT_PLACES-2:0], 1'b1};
        drop    = ins_at >= limit;
    end

    // Shifted list with the new entry in place
    always_comb begin
        for (int k = 0; k < OUT_PLACES; k++) begin
            ins_idx[k]  = rk_idx_reg[k];
            ins_id[k]   = rk_id_reg[k];
            ins_prio[k] = rk_prio_reg[k];
            if (!ge[k] && ge_prev[k]) begin
                ins_idx[k]  = i_reg;
                ins_id[k]   = cur_id_reg;
                ins_prio[k] = cur_prio_reg;
            end
        end
        for (int k = 1; k < OUT_PLACES; k++) begin
            if (!ge[k] && !ge_prev[k]) begin
                ins_idx[k]  = rk_idx_reg[k-1];
                ins_id[k]   = rk_id_reg[k-1];
                ins_prio[k] = rk_prio_reg[k-1];
            end
        end
    end

    // Result for the current output slot, or the empty marker
    assign emit_last = (rk_cnt_reg == '0) || (COUNT_W'(k_reg) + COUNT_W'(1) == rk_cnt_reg);

    always_comb begin
        emit_data                = '0;
        emit_user.list_overflow  = ovf_reg;
        emit_user.none_selected  = (rk_cnt_reg == '0);
        if (rk_cnt_reg != '0) begin
            emit_data.entry_index    = INDEX_W'(rk_idx_reg[k_reg]);
            emit_data.selected_id    = rk_id_reg[k_reg];
            emit_data.rank           = RANK_W'(k_reg);
            emit_data.selected_count = rk_cnt_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loaded_reg    <= '0;
            ovf_reg       <= 1'b0;
            time_reg      <= '0;
            max_shown_reg <= MAX_SHOWN_RST;
            i_reg         <= '0;
            j_reg         <= '0;
            rk_cnt_reg    <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            // hold configuration
            if (cfg_valid) begin
                max_shown_reg <= cfg_data;
            end

            // load the store
            if (s_fire) begin
                if (store_ok) begin
                    loaded_reg <= loaded_reg + CW'(1);
                end else begin
                    ovf_reg <= 1'b1;
                end
                if (s_tlast) begin
                    time_reg <= in_word.current_time;
                end
            end

            // walk the store
            if (cmd.sel_start) begin
                i_reg      <= '0;
                rk_cnt_reg <= '0;
                k_reg      <= '0;
            end
            if (cmd.cap) begin
                j_reg <= CW'(i_reg) + CW'(1);
            end
            if (cmd.j_inc) begin
                j_reg <= j_reg + CW'(1);
            end
            if (cmd.i_inc) begin
                i_reg <= i_reg + IDXW'(1);
            end
            if (cmd.insert && !drop && (rk_cnt_reg < limit)) begin
                rk_cnt_reg <= rk_cnt_reg + COUNT_W'(1);
            end

            // emit results, then reopen the store
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
                if (emit_last) begin
                    k_reg      <= '0;
                    loaded_reg <= '0;
                    ovf_reg    <= 1'b0;
                end else begin
                    k_reg <= k_reg + KW'(1);
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            cur_id_reg   <= rd_entry.id;
            cur_prio_reg <= rd_entry.prio;
        end
        if (cmd.insert && !drop) begin
            for (int k = 0; k < OUT_PLACES; k++) begin
                rk_idx_reg[k]  <= ins_idx[k];
                rk_id_reg[k]   <= ins_id[k];
                rk_prio_reg[k] <= ins_prio[k];
            end
        end
        if (cmd.emit) begin
            out_data_reg <= emit_data;
            out_user_reg <= emit_user;
            out_last_reg <= emit_last;
        end
    end

    // Status to the controller; load_last is only looked at while loading
    assign st.load_last = s_tvalid & s_tlast;
    assign st.empty     = (loaded_reg == '0);
    assign st.skip      = (rd_entry.id == '0) ||
                          ((rd_entry.expiry != '0) && (time_reg >= rd_entry.expiry));
    assign st.dup       = (rd_entry.id == cur_id_reg);
    assign st.last_i    = (CW'(i_reg) + CW'(1) == loaded_reg);
    assign st.last_j    = (j_reg + CW'(1) == loaded_reg);
    assign st.out_free  = !out_valid_reg || m_tready;
    assign st.emit_last = emit_last;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* hw/rtl/top_k_priority_select_dedup.sv */
// Loading: one item per cycle. Selection after the item marked last: a start step,
// then per entry a read and a capture, a read and a compare per later entry in the
// duplicate scan, and an insert; entries are read one at a time through the single
// store read port. Results leave one per cycle via an output register while m_tready
// is high; the next list loads once the last result is registered. Reset clears
// control state and sets max_shown to 8.
// ----------------------------------------------------------------------------
// top_k_priority_select_dedup
// Ranked top-k selection with expiry filtering and id deduplication over a
// loaded list of entries.
// ----------------------------------------------------------------------------
module top_k_priority_select_dedup #(
    parameter int MAX_ENTRIES = tkps_pkg::MAX_ENTRIES_DEF,
    parameter int TOP_K       = tkps_pkg::TOP_K_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // entry_id[63:0], expiry_time[95:64], priority_req[111:96], current_time[143:112]
    input  logic [tkps_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                             s_tlast,   // last_entry
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // entry_index[5:0], selected_id[69:6], rank[72:70], selected_count[76:73], zero pad
    output logic [tkps_pkg::OUT_TDATA_W-1:0] m_tdata,
    // none_selected[0], list_overflow[1]
    output logic [tkps_pkg::OUT_TUSER_W-1:0] m_tuser,
    output logic                             m_tlast,   // last_result
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tkps_pkg::SHOWN_W-1:0]     cfg_data   // max_shown
);
    import tkps_pkg::*;

    tkps_cmd_t    cmd;
    tkps_status_t st;
    tkps_out_t    out_view;
    tkps_user_t   user_view;

    tkps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .st      (st),
        .cmd     (cmd)
    );

    tkps_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .TOP_K       (TOP_K)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    assign out_view  = m_tdata;
    assign user_view = m_tuser;

    // An empty run is a single result with all data fields zero
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && user_view.none_selected) |-> (m_tlast && (m_tdata == '0)))
        else $error("empty result carries data or is not last");

    // A selected entry ranks inside the run's count
    a_rank_in_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !user_view.none_selected) |->
        (COUNT_W'(out_view.rank) < out_view.selected_count))
        else $error("rank outside selected count");

    // The final result of a run sits at the last rank
    a_last_rank: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !user_view.none_selected && m_tlast) |->
        (COUNT_W'(out_view.rank) + COUNT_W'(1) == out_view.selected_count))
        else $error("last result not at final rank");

    // After the final result is registered the store reopens
    a_reopen: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && st.emit_last) |=> s_tready)
        else $error("input not reopened after run");

endmodule

/* test/tb_top_k_priority_select_dedup.sv */
// ----------------------------------------------------------------------------
// tb_top_k_priority_select_dedup
// Self-checking bench for the top-k priority select block: loads entry lists
// through the input stream, predicts the ranked selection of each list after
// id, expiry and duplicate filtering, and compares every result item.
// ----------------------------------------------------------------------------
module tb_top_k_priority_select_dedup;

    timeunit 1ns;
    timeprecision 1ps;

    import tkps_pkg::*;

    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 40000;
    localparam int SETTLE_CYCLES = 16;
    localparam int SHOW_ERRORS   = 10;

    // Expected result item
    typedef struct {
        tkps_out_t  data;
        tkps_user_t user;
        logic       is_last;
    } sel_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [SHOWN_W-1:0]     cfg_data;

    // Predictor state: the list being loaded and the current register value
    tkps_entry_t        entry_list[$];
    bit                 list_overflowed = 1'b0;
    logic [SHOWN_W-1:0] shown_setting   = MAX_SHOWN_RST;
    sel_result_t        results_due[$];

    int tx_gap_pct      = 0;
    int rx_stall_pct    = 0;
    int hold_reqs       = 0;
    int mismatches      = 0;
    int entries_sent    = 0;
    int lists_sent      = 0;
    int results_checked = 0;

    top_k_priority_select_dedup u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // Rank the loaded list and queue the result items it must produce
    function automatic void predict_ranking(input logic [TIME_W-1:0] now);
        int          limit;
        int          n_ranked;
        int          at;
        int          top;
        int          ranked[OUT_PLACES];
        bit          replaced;
        sel_result_t r;
        limit = (shown_setting > TOP_K_DEF) ? TOP_K_DEF : int'(shown_setting);
        if (limit > OUT_PLACES) limit = OUT_PLACES;
        n_ranked = 0;
        for (int i = 0; i < entry_list.size(); i++) begin
            // skip invalid ids and expired entries
            if (entry_list[i].id == '0) continue;
            if (entry_list[i].expiry != '0 && now >= entry_list[i].expiry) continue;
            // a later entry with the same id replaces this one
            replaced = 1'b0;
            for (int j = i + 1; j < entry_list.size(); j++)
                if (entry_list[j].id == entry_list[i].id) replaced = 1'b1;
            if (replaced) continue;
            // find the place after all entries of equal or higher priority
            at = 0;
            while (at < n_ranked &&
                   $signed(entry_list[ranked[at]].prio) >= $signed(entry_list[i].prio))
                at++;
            if (at >= limit) continue;
            top = (n_ranked < limit - 1) ? n_ranked : limit - 1;
            for (int j = top; j > at; j--) ranked[j] = ranked[j-1];
            ranked[at] = i;
            if (n_ranked < limit) n_ranked++;
        end

        r.data    = '0;
        r.user    = '0;
        r.is_last = 1'b0;
        r.user.list_overflow = list_overflowed;
        if (n_ranked == 0) begin
            r.user.none_selected = 1'b1;
            r.is_last            = 1'b1;
            results_due.push_back(r);
        end else begin
            for (int k = 0; k < n_ranked; k++) begin
                r.data.entry_index    = INDEX_W'(ranked[k]);
                r.data.selected_id    = entry_list[ranked[k]].id;
                r.data.rank           = RANK_W'(k);
                r.data.selected_count = COUNT_W'(n_ranked);
                r.is_last             = (k == n_ranked - 1);
                results_due.push_back(r);
            end
        end
    endfunction

    // Store an accepted item; the item marked last closes the list
    function automatic void record_entry(input tkps_in_t item, input bit is_last);
        tkps_entry_t e;
        if (entry_list.size() < MAX_ENTRIES_DEF) begin
            e.id     = item.entry_id;
            e.expiry = item.expiry_time;
            e.prio   = item.priority_req;
            entry_list.push_back(e);
        end else begin
            list_overflowed = 1'b1;
        end
        if (is_last) begin
            predict_ranking(item.current_time);
            entry_list.delete();
            list_overflowed = 1'b0;
            lists_sent++;
        end
    endfunction

    // Compare one result item with the oldest expectation
    task automatic check_selection(input tkps_out_t got, input tkps_user_t got_user,
                                   input logic got_last);
        sel_result_t want;
        if (results_due.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOW_ERRORS)
                $display("ERROR: unexpected result: idx=%0d id=%h rank=%0d cnt=%0d",
                         got.entry_index, got.selected_id, got.rank, got.selected_count);
        end else begin
            want = results_due.pop_front();
            results_checked++;
            if (got.entry_index !== want.data.entry_index ||
                got.selected_id !== want.data.selected_id ||
                got.rank !== want.data.rank ||
                got.selected_count !== want.data.selected_count ||
                got_user.none_selected !== want.user.none_selected ||
                got_user.list_overflow !== want.user.list_overflow ||
                got_last !== want.is_last) begin
                mismatches++;
                if (mismatches <= SHOW_ERRORS) begin
                    $display("ERROR: want idx=%0d id=%h rank=%0d cnt=%0d none=%b ovf=%b last=%b",
                             want.data.entry_index, want.data.selected_id, want.data.rank,
                             want.data.selected_count, want.user.none_selected,
                             want.user.list_overflow, want.is_last);
                    $display("       got  idx=%0d id=%h rank=%0d cnt=%0d none=%b ovf=%b last=%b",
                             got.entry_index, got.selected_id, got.rank, got.selected_count,
                             got_user.none_selected, got_user.list_overflow, got_last);
                end
            end
        end
    endtask

    // Check every accepted result item
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
            check_selection(m_tdata, m_tuser, m_tlast);
    end

    // Drive ready: random stalls, or a long hold-off when one is requested
    initial begin : rx_ready
        int hold_served;
        hold_served = 0;
        forever begin
            @(posedge aclk);
            if (hold_reqs != hold_served) begin
                hold_served++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Offer one item, with a random gap first, and wait until it is taken
    task automatic send_entry(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] expiry,
                              input logic [PRIO_W-1:0] prio, input logic [TIME_W-1:0] now,
                              input bit is_last);
        tkps_in_t item;
        item.entry_id     = id;
        item.expiry_time  = expiry;
        item.priority_req = prio;
        item.current_time = now;
        while ($urandom_range(99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= item;
        s_tlast  <= is_last;
        do @(posedge aclk); while (s_tready !== 1'b1);
        entries_sent++;
        record_entry(item, is_last);
    endtask

    // Random entry around a given current time; small id pool for duplicates
    function automatic tkps_in_t random_entry(input logic [TIME_W-1:0] now);
        tkps_in_t item;
        case ($urandom_range(9))
            0:       item.entry_id = '0;
            1, 2:    item.entry_id = {$urandom(), $urandom()};
            default: item.entry_id = ID_W'($urandom_range(12, 1));
        endcase
        case ($urandom_range(9))
            0, 1, 2: item.expiry_time = '0;
            3:       item.expiry_time = now;
            4:       item.expiry_time = now + 1;
            5:       item.expiry_time = now - 1;
            default: item.expiry_time = $urandom();
        endcase
        if ($urandom_range(1) == 0)
            item.priority_req = PRIO_W'($urandom_range(3) - 1);
        else
            item.priority_req = PRIO_W'($urandom());
        item.current_time = now;
        return item;
    endfunction

    task automatic send_random_list(input int count);
        logic [TIME_W-1:0] now;
        tkps_in_t          item;
        case ($urandom_range(9))
            0:       now = '0;
            1:       now = '1;
            default: now = $urandom();
        endcase
        for (int k = 0; k < count; k++) begin
            item = random_entry(now);
            // the current time only counts on the item marked last
            send_entry(item.entry_id, item.expiry_time, item.priority_req,
                       (k == count - 1) ? now : $urandom(), k == count - 1);
        end
    endtask

    // Drop valid, wait for every expected result, then let the block settle
    task automatic wait_drained();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (results_due.size() != 0 && waited < DRAIN_CYCLES) begin
            @(posedge aclk);
            waited++;
        end
        if (results_due.size() != 0) begin
            mismatches += results_due.size();
            if (mismatches <= SHOW_ERRORS)
                $display("ERROR: %0d expected results never arrived", results_due.size());
            results_due.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_max_shown(input logic [SHOWN_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        cfg_valid     <= 1'b0;
        shown_setting  = value;
    endtask

    // Field extremes, expiry boundaries, dedup, ties and dropping past the limit
    task automatic test_directed_edges();
        logic [PRIO_W-1:0] prios[10];
        prios = '{16'd3, 16'd9, 16'hfffb, 16'd9, 16'd0, 16'd7, 16'd12, 16'hfffb, 16'd1, 16'd2};
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        // mixed list: zero id, expired at equal time, replaced duplicate, ties
        send_entry(64'd0, 32'd0, 16'h7fff, 32'd100, 1'b0);
        send_entry('1, 32'd0, 16'h8000, 32'd0, 1'b0);
        send_entry(64'd5, 32'd100, 16'd10, 32'd7, 1'b0);
        send_entry(64'd6, 32'd101, 16'd10, 32'd7, 1'b0);
        send_entry(64'd7, 32'hffff_ffff, 16'h7fff, 32'hffff_ffff, 1'b0);
        send_entry(64'd8, 32'd0, 16'd10, 32'd0, 1'b0);
        send_entry(64'd9, 32'd0, 16'd0, 32'd0, 1'b0);
        send_entry(64'd9, 32'd50, 16'd0, 32'd0, 1'b0);
        send_entry(64'd10, 32'd0, 16'hffff, 32'd100, 1'b1);
        // single invalid entry: nothing survives
        send_entry(64'd0, 32'd0, 16'd0, 32'd0, 1'b1);
        // latest possible time
        send_entry(64'h8000_0000_0000_0001, 32'hffff_ffff, 16'd4, 32'd0, 1'b0);
        send_entry(64'd1, 32'd0, 16'd5, 32'hffff_ffff, 1'b1);
        // ten survivors, two ranked past eight places
        for (int k = 0; k < 10; k++)
            send_entry(64'd21 + ID_W'(k), 32'd0, prios[k], 32'd5, k == 9);
        wait_drained();
    endtask

    // Register extremes: zero places, one place, clamped settings
    task automatic test_limit_settings();
        write_max_shown(4'd0);
        for (int k = 0; k < 3; k++)
            send_entry(64'd41 + ID_W'(k), 32'd0, PRIO_W'(k + 1), 32'd9, k == 2);
        wait_drained();
        write_max_shown(4'd1);
        for (int k = 0; k < 4; k++)
            send_entry(64'd51 + ID_W'(k), 32'd0, (k < 2) ? 16'd5 : 16'd9, 32'd9, k == 3);
        wait_drained();
        write_max_shown(4'd15);
        for (int k = 0; k < 10; k++)
            send_entry(64'd61 + ID_W'(k), 32'd0, PRIO_W'(100 - k), 32'd9, k == 9);
        wait_drained();
        write_max_shown(4'd9);
        send_random_list(10);
        wait_drained();
        write_max_shown(MAX_SHOWN_RST);
    endtask

    // Full store, one entry past it, which is the ignored entry marked last
    task automatic test_store_overflow();
        send_random_list(MAX_ENTRIES_DEF + 1);
        wait_drained();
    endtask

    // Hold the output off for a long stretch while the next list is offered
    task automatic test_output_holdoff();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        hold_reqs   <= hold_reqs + 1;
        send_random_list(6);
        send_random_list(10);
        send_random_list(3);
        wait_drained();
    endtask

    // Random lists under one idling pattern and one register setting
    task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                       input logic [SHOWN_W-1:0] shown, input int goal);
        int start;
        int count;
        wait_drained();
        write_max_shown(shown);
        tx_gap_pct   = tx_pct;
        rx_stall_pct = rx_pct;
        start        = entries_sent;
        while (entries_sent - start < goal) begin
            if ($urandom_range(99) < 5)
                count = $urandom_range(8, 5);
            else
                count = $urandom_range(4, 1);
            send_random_list(count);
        end
        wait_drained();
    endtask

    initial begin : main
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_edges();
        test_limit_settings();
        test_store_overflow();
        test_output_holdoff();
        test_random_traffic(0, 0, MAX_SHOWN_RST, 5);
        test_random_traffic(64, 0, 4'd3, 5);
        test_random_traffic(0, 64, 4'd15, 5);
        test_random_traffic(7, 7, SHOWN_W'($urandom_range(15)), 5);

        $display("summary: %0d lists, %0d entries, %0d results checked, %0d mismatches",
                 lists_sent, entries_sent, results_checked, mismatches);
        $display("summary: max_shown 0/1/3/8/9/15, store overflow, long output hold-off");
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Give up on a hung run
    initial begin : watchdog
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
